// File: hdl/trap_pkg.sv
package trap_pkg;

    localparam int FRAC_BITS = 32;
    localparam int DATA_W    = 48;
    localparam int HALF_W    = DATA_W / 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CNT_W     = $clog2(DATA_W);

    localparam int APB_W     = 64;
    localparam int REG_IDX_W = 2;
    localparam int ADDR_W    = REG_IDX_W + 3;

    localparam logic [REG_IDX_W-1:0] REG_PATH_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ACCEL   = 2'd2;

    localparam logic [DATA_W-1:0] DATA_MAX  = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] ACCEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [DATA_W-1:0] PATH_LENGTH_RST = 48'd6476658084;
    localparam logic [DATA_W-1:0] MAX_SPEED_RST   = 48'd214748365;
    localparam logic [DATA_W-1:0] MAX_ACCEL_RST   = 48'd42949673;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CS_START,
        CS_MUL_LA,
        CS_MUL_VV,
        CS_CHECK,
        CS_DIV_RAMP,
        CS_DIV_CRUISE,
        CS_DIV_OFF,
        CS_IDLE
    } calc_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] path_length;
        logic [DATA_W-1:0] max_speed;
        logic [DATA_W-1:0] max_accel;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] ramp_time;
        logic [DATA_W-1:0] dec_start;
        logic [DATA_W-1:0] end_time;
        logic [DATA_W-1:0] offset;
        logic              invalid;
    } prof_t;

    typedef struct packed {
        logic pp;
        logic sum;
        logic prod;
    } mul_en_t;

    // Shift a full product right and clamp it to the data width.
    function automatic logic [DATA_W-1:0] sat_shr(input logic [PROD_W-1:0] p,
                                                  input int unsigned sh);
        logic [PROD_W-1:0] q;
        q = p >> sh;
        if (|q[PROD_W-1:DATA_W])
            return DATA_MAX;
        return q[DATA_W-1:0];
    endfunction

endpackage

// File: hdl/trapezoidal_motion_profile.sv
// Trapezoidal velocity profile evaluator. Each input beat carries a time value (unsigned
// Q16.32 s); each output beat gives position, speed, signed acceleration and total move time
// (Q16.32) plus the phase (accelerate, cruise, decelerate, done) and an invalid flag, which is
// set, with all other fields zero, when speed or acceleration is zero or the length does
// not exceed speed squared over acceleration. Registers over APB at byte addresses 0x00
// path_length, 0x08 max_speed, 0x10 max_accel (48 bits each). The ramp time, end time
// and cruise offset are derived by a bit-serial multiplier and divider after reset and
// after every register write, while s_tready stays low. Once idle the block takes one
// beat per cycle unless m_tready holds the output back; the pipeline holds two chained
// 48x48 multiplies, each cut into three stages of 24x24 partial products.
module trapezoidal_motion_profile
    import trap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // time_now[47:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [191:0]      m_tdata,   // position, speed, accel, move_time (48 each)
    output logic [2:0]        m_tuser,   // phase[1:0], profile_invalid[2]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    localparam int NUM_STAGES = 8;

    cfg_t  cfg;
    prof_t prof;
    logic  busy;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;
    logic                  s_accept;

    phase_t            ph_reg [0:6];
    logic [DATA_W-1:0] x_reg  [0:3];
    logic [DATA_W-1:0] m_reg;
    logic [DATA_W-1:0] p1_reg [4:6];

    phase_t            ph_in;
    logic [DATA_W-1:0] x_in;
    logic [DATA_W-1:0] m_in;
    logic [DATA_W-1:0] t_in;

    logic [PROD_W-1:0] prod1;
    logic [PROD_W-1:0] prod2;
    logic [DATA_W-1:0] p1;
    logic [DATA_W-1:0] tail;
    logic [DATA_W-1:0] mag;

    logic [DATA_W-1:0] pos_out_reg, pos_out_next;
    logic [DATA_W-1:0] spd_out_reg, spd_out_next;
    logic [DATA_W-1:0] acc_out_reg, acc_out_next;
    logic [DATA_W-1:0] mtime_out_reg, mtime_out_next;
    phase_t            ph_out_reg, ph_out_next;
    logic              inv_out_reg, inv_out_next;

    trap_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .prof    (prof),
        .busy    (busy)
    );

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    assign s_tready = adv[0] && !busy;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (adv[0])
                valid_reg[0] <= s_accept;
            for (int k = 1; k < NUM_STAGES; k++)
                if (adv[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // Stage 0: pick the phase; in deceleration measure time back from the end.
    assign t_in = s_tdata[DATA_W-1:0];

    always_comb
    begin
        priority if (t_in <= prof.ramp_time)
        begin
            ph_in = PH_ACCEL;
            x_in  = t_in;
            m_in  = cfg.max_accel;
        end
        else if (t_in <= prof.dec_start)
        begin
            ph_in = PH_CRUISE;
            x_in  = t_in;
            m_in  = cfg.max_speed;
        end
        else if (t_in <= prof.end_time)
        begin
            ph_in = PH_DECEL;
            x_in  = prof.end_time - t_in;
            m_in  = cfg.max_accel;
        end
        else
        begin
            ph_in = PH_DONE;
            x_in  = t_in;
            m_in  = cfg.max_accel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ph_reg[0] <= ph_in;
            x_reg[0]  <= x_in;
            m_reg     <= m_in;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++)
            if (adv[k])
                ph_reg[k] <= ph_reg[k-1];
        for (int k = 1; k < 4; k++)
            if (adv[k])
                x_reg[k] <= x_reg[k-1];
        if (adv[4])
            p1_reg[4] <= p1;
        for (int k = 5; k < NUM_STAGES - 1; k++)
            if (adv[k])
                p1_reg[k] <= p1_reg[k-1];
    end

    // Stages 1-3: speed (or V*t in cruise).
    trap_mul u_mul_speed (
        .clk  (clk),
        .en   ('{pp: adv[1], sum: adv[2], prod: adv[3]}),
        .a    (m_reg),
        .b    (x_reg[0]),
        .prod (prod1)
    );

    assign p1 = sat_shr(prod1, FRAC_BITS);

    // Stages 4-6: speed times time for the ramp distance.
    trap_mul u_mul_dist (
        .clk  (clk),
        .en   ('{pp: adv[4], sum: adv[5], prod: adv[6]}),
        .a    (p1),
        .b    (x_reg[3]),
        .prod (prod2)
    );

    assign tail = sat_shr(prod2, FRAC_BITS + 1);
    assign mag  = (cfg.max_accel > ACCEL_MAX) ? ACCEL_MAX : cfg.max_accel;

    // Stage 7: assemble the result beat.
    always_comb
    begin
        mtime_out_next = prof.end_time;
        ph_out_next    = ph_reg[6];
        inv_out_next   = 1'b0;
        unique case (ph_reg[6])
            PH_ACCEL:
            begin
                pos_out_next = tail;
                spd_out_next = p1_reg[6];
                acc_out_next = mag;
            end
            PH_CRUISE:
            begin
                pos_out_next = (p1_reg[6] > prof.offset) ? p1_reg[6] - prof.offset : '0;
                spd_out_next = cfg.max_speed;
                acc_out_next = '0;
            end
            PH_DECEL:
            begin
                pos_out_next = (cfg.path_length > tail) ? cfg.path_length - tail : '0;
                spd_out_next = p1_reg[6];
                acc_out_next = DATA_W'(0) - mag;
            end
            PH_DONE:
            begin
                pos_out_next = cfg.path_length;
                spd_out_next = '0;
                acc_out_next = '0;
            end
            default:
            begin
                pos_out_next = '0;
                spd_out_next = '0;
                acc_out_next = '0;
            end
        endcase
        if (prof.invalid)
        begin
            pos_out_next   = '0;
            spd_out_next   = '0;
            acc_out_next   = '0;
            mtime_out_next = '0;
            ph_out_next    = PH_ACCEL;
            inv_out_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NUM_STAGES-1])
        begin
            pos_out_reg   <= pos_out_next;
            spd_out_reg   <= spd_out_next;
            acc_out_reg   <= acc_out_next;
            mtime_out_reg <= mtime_out_next;
            ph_out_reg    <= ph_out_next;
            inv_out_reg   <= inv_out_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {mtime_out_reg, acc_out_reg, spd_out_reg, pos_out_reg};
    assign m_tuser  = {inv_out_reg, ph_out_reg};

`ifndef SYNTH
    a_invalid_zeros: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && inv_out_reg) |-> (pos_out_reg == '0 && spd_out_reg == '0 &&
            acc_out_reg == '0 && mtime_out_reg == '0 && ph_out_reg == PH_ACCEL))
        else $error("invalid profile beat carries nonzero fields");

    a_cruise_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !inv_out_reg && ph_out_reg == PH_CRUISE) |->
            (spd_out_reg == cfg.max_speed && acc_out_reg == '0))
        else $error("cruise beat not at top speed");

    a_decel_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !inv_out_reg && ph_out_reg == PH_DECEL) |-> acc_out_reg[DATA_W-1])
        else $error("deceleration beat without negative acceleration");

    a_done_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !inv_out_reg && ph_out_reg == PH_DONE) |->
            (spd_out_reg == '0 && pos_out_reg == cfg.path_length))
        else $error("finished move not at rest at the path end");
`endif

endmodule

// File: hdl/trap_mul.sv
module trap_mul
    import trap_pkg::*;
(
    input  logic              clk,
    input  mul_en_t           en,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [PROD_W-1:0] prod
);

    logic [DATA_W-1:0] pp_ll_reg;
    logic [DATA_W-1:0] pp_lh_reg;
    logic [DATA_W-1:0] pp_hl_reg;
    logic [DATA_W-1:0] pp_hh_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W:0]   mid_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [DATA_W-1:0] pp_ll_next;
    logic [DATA_W-1:0] pp_lh_next;
    logic [DATA_W-1:0] pp_hl_next;
    logic [DATA_W-1:0] pp_hh_next;
    logic [DATA_W:0]   mid_next;
    logic [PROD_W-1:0] prod_next;

    assign pp_ll_next = DATA_W'(a[HALF_W-1:0])      * DATA_W'(b[HALF_W-1:0]);
    assign pp_lh_next = DATA_W'(a[HALF_W-1:0])      * DATA_W'(b[DATA_W-1:HALF_W]);
    assign pp_hl_next = DATA_W'(a[DATA_W-1:HALF_W]) * DATA_W'(b[HALF_W-1:0]);
    assign pp_hh_next = DATA_W'(a[DATA_W-1:HALF_W]) * DATA_W'(b[DATA_W-1:HALF_W]);

    assign mid_next  = {1'b0, pp_lh_reg} + {1'b0, pp_hl_reg};
    // High and low partial products do not overlap, so they concatenate.
    assign prod_next = {hi_reg, lo_reg} + (PROD_W'(mid_reg) << HALF_W);

    always_ff @(posedge clk)
    begin
        if (en.pp)
        begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
        end
        if (en.sum)
        begin
            lo_reg  <= pp_ll_reg;
            hi_reg  <= pp_hh_reg;
            mid_reg <= mid_next;
        end
        if (en.prod)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: hdl/trap_cfg.sv
module trap_cfg
    import trap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg,
    output prof_t             prof,
    output logic              busy
);

    logic [DATA_W-1:0] path_length_reg;
    logic [DATA_W-1:0] max_speed_reg;
    logic [DATA_W-1:0] max_accel_reg;

    calc_state_t       state_reg, state_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sat_reg, sat_next;
    logic [PROD_W-1:0] la_reg, la_next;
    logic [PROD_W-1:0] vv_reg, vv_next;
    logic              invalid_reg, invalid_next;
    logic [DATA_W-1:0] ramp_reg, ramp_next;
    logic [DATA_W-1:0] end_reg, end_next;
    logic [DATA_W-1:0] off_reg, off_next;
    logic [DATA_W-1:0] dec_reg, dec_next;

    logic              wr;
    logic [REG_IDX_W-1:0] wr_idx;
    logic              step_last;
    logic [DATA_W-1:0] mcand;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W:0]   mul_sum;
    logic [PROD_W-1:0] prod_now;
    logic [DATA_W:0]   div_trial;
    logic              div_ge;
    logic [DATA_W-1:0] div_rem;
    logic [DATA_W-1:0] quot_now;
    logic [DATA_W-1:0] div_result;
    logic [DATA_W:0]   end_sum;
    logic              ld_en;
    logic [PROD_W-1:0] ld_dividend;
    logic [DATA_W-1:0] ld_divisor;

    assign wr     = psel && penable && pwrite && pready;
    assign wr_idx = paddr[ADDR_W-1:3];
    assign pready = 1'b1;

    always_comb
    begin
        unique case (wr_idx)
            REG_PATH_LENGTH: prdata = APB_W'(path_length_reg);
            REG_MAX_SPEED:   prdata = APB_W'(max_speed_reg);
            REG_MAX_ACCEL:   prdata = APB_W'(max_accel_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_length_reg <= PATH_LENGTH_RST;
            max_speed_reg   <= MAX_SPEED_RST;
            max_accel_reg   <= MAX_ACCEL_RST;
        end
        else if (wr)
        begin
            unique case (wr_idx)
                REG_PATH_LENGTH: path_length_reg <= pwdata[DATA_W-1:0];
                REG_MAX_SPEED:   max_speed_reg   <= pwdata[DATA_W-1:0];
                REG_MAX_ACCEL:   max_accel_reg   <= pwdata[DATA_W-1:0];
                default:         ;
            endcase
        end
    end

    // Shared shift-add multiplier and restoring divider, one bit per cycle.
    assign step_last  = (cnt_reg == CNT_W'(DATA_W - 1));
    assign mcand      = (state_reg == CS_MUL_LA) ? path_length_reg : max_speed_reg;
    assign divisor    = (state_reg == CS_DIV_CRUISE) ? max_speed_reg : max_accel_reg;
    assign mul_sum    = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand} : '0);
    assign prod_now   = {mul_sum, lo_reg[DATA_W-1:1]};
    assign div_trial  = {hi_reg, lo_reg[DATA_W-1]};
    assign div_ge     = (div_trial >= {1'b0, divisor});
    assign div_rem    = div_ge ? DATA_W'(div_trial - {1'b0, divisor}) : div_trial[DATA_W-1:0];
    assign quot_now   = {lo_reg[DATA_W-2:0], div_ge};
    assign div_result = sat_reg ? DATA_MAX : quot_now;
    assign end_sum    = {1'b0, ramp_reg} + {1'b0, div_result};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_START;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        cnt_next     = cnt_reg;
        sat_next     = sat_reg;
        la_next      = la_reg;
        vv_next      = vv_reg;
        invalid_next = invalid_reg;
        ramp_next    = ramp_reg;
        end_next     = end_reg;
        off_next     = off_reg;
        dec_next     = dec_reg;
        ld_en        = 1'b0;
        ld_dividend  = '0;
        ld_divisor   = max_accel_reg;

        unique case (state_reg)
            CS_START:
            begin
                hi_next    = '0;
                lo_next    = max_accel_reg;
                cnt_next   = '0;
                state_next = CS_MUL_LA;
            end
            CS_MUL_LA, CS_MUL_VV:
            begin
                hi_next  = mul_sum[DATA_W:1];
                lo_next  = {mul_sum[0], lo_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (step_last)
                begin
                    if (state_reg == CS_MUL_LA)
                    begin
                        la_next    = prod_now;
                        hi_next    = '0;
                        lo_next    = max_speed_reg;
                        cnt_next   = '0;
                        state_next = CS_MUL_VV;
                    end
                    else
                    begin
                        vv_next    = prod_now;
                        state_next = CS_CHECK;
                    end
                end
            end
            CS_CHECK:
            begin
                invalid_next = (max_speed_reg == '0) || (max_accel_reg == '0) ||
                               (la_reg <= vv_reg);
                ld_en        = 1'b1;
                ld_dividend  = PROD_W'(max_speed_reg) << FRAC_BITS;
                ld_divisor   = max_accel_reg;
                state_next   = CS_DIV_RAMP;
            end
            CS_DIV_RAMP, CS_DIV_CRUISE, CS_DIV_OFF:
            begin
                hi_next  = div_rem;
                lo_next  = quot_now;
                cnt_next = cnt_reg + 1'b1;
                if (step_last)
                begin
                    if (state_reg == CS_DIV_RAMP)
                    begin
                        ramp_next   = div_result;
                        ld_en       = 1'b1;
                        ld_dividend = PROD_W'(path_length_reg) << FRAC_BITS;
                        ld_divisor  = max_speed_reg;
                        state_next  = CS_DIV_CRUISE;
                    end
                    else if (state_reg == CS_DIV_CRUISE)
                    begin
                        end_next    = end_sum[DATA_W] ? DATA_MAX : end_sum[DATA_W-1:0];
                        ld_en       = 1'b1;
                        ld_dividend = vv_reg;
                        ld_divisor  = max_accel_reg;
                        state_next  = CS_DIV_OFF;
                    end
                    else
                    begin
                        off_next   = div_result >> 1;
                        dec_next   = end_reg - ramp_reg;
                        state_next = CS_IDLE;
                    end
                end
            end
            CS_IDLE:
            begin
            end
            default:
            begin
                state_next = CS_START;
            end
        endcase

        if (ld_en)
        begin
            hi_next  = ld_dividend[PROD_W-1:DATA_W];
            lo_next  = ld_dividend[DATA_W-1:0];
            cnt_next = '0;
            // Quotient would not fit: clamp to all ones.
            sat_next = (ld_dividend[PROD_W-1:DATA_W] >= ld_divisor);
        end

        // Restart on every write, even mid-computation.
        if (wr)
            state_next = CS_START;
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        cnt_reg     <= cnt_next;
        sat_reg     <= sat_next;
        la_reg      <= la_next;
        vv_reg      <= vv_next;
        invalid_reg <= invalid_next;
        ramp_reg    <= ramp_next;
        end_reg     <= end_next;
        off_reg     <= off_next;
        dec_reg     <= dec_next;
    end

    assign busy             = (state_reg != CS_IDLE);
    assign cfg.path_length  = path_length_reg;
    assign cfg.max_speed    = max_speed_reg;
    assign cfg.max_accel    = max_accel_reg;
    assign prof.ramp_time   = invalid_reg ? '0 : ramp_reg;
    assign prof.dec_start   = invalid_reg ? '0 : dec_reg;
    assign prof.end_time    = invalid_reg ? '0 : end_reg;
    assign prof.offset      = off_reg;
    assign prof.invalid     = invalid_reg;

`ifndef SYNTH
    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        wr |=> busy)
        else $error("register write did not restart the profile computation");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && prof.invalid) |-> (prof.ramp_time == '0 && prof.end_time == '0))
        else $error("invalid profile left nonzero ramp or end time");

    a_dec_start: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (DATA_W'(prof.dec_start + prof.ramp_time) == prof.end_time))
        else $error("decel start inconsistent with ramp and end time");
`endif

endmodule
